/* hw/rtl/bht_pkg.sv */
// ----------------------------------------------------------------------------
// Buddy hole table package
// Shared constants, codes and the table entry layout.
// ----------------------------------------------------------------------------
package bht_pkg;

    // Table geometry.
    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Field widths fixed by the interface.
    localparam int SIZE_W  = 17;
    localparam int ADDR_W  = 16;
    localparam int KIND_W  = 2;
    localparam int ENTRY_W = SIZE_W + ADDR_W;

    // Operation codes carried on the kind field.
    localparam logic [KIND_W-1:0] KIND_TAKE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GIVE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BUDDY = 2'd2;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // One table entry as held in the memory.
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] start;
    } entry_t;

endpackage

/* hw/rtl/bht_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/buddy_hole_table_top.sv */
// ----------------------------------------------------------------------------
// Buddy hole table
// Size-ordered table of free memory holes serving take, give and buddy
// requests for a buddy-style allocator.
// ----------------------------------------------------------------------------
// The table holds up to 64 free holes, each a 17-bit size and a 16-bit start
// address in chunk units, kept smallest first with older holes ahead of newer
// ones of the same size. A take request removes the smallest hole that fits
// and returns its address; a give request inserts a hole behind every hole of
// equal or smaller size, or reports a full table and drops it; a buddy request
// removes a hole of exactly the requested size that starts directly below or
// directly above the given address. Each request is one transfer on the s_
// channel and yields exactly one transfer on the m_ channel. The entries live
// in a single-port-read, single-port-write memory that is walked one entry per
// cycle by a small sequencer, with one shared compare unit judging each entry
// as it streams past and the same walk shifting entries to close or open a gap.
// A take or buddy request therefore walks all N holes in the table and a give
// at most N, with the memory read port yielding one entry per cycle. Take and
// buddy requests with an empty table, a give into a full table and an unused
// kind code skip the walk, and a give into an empty table writes its hole at
// the front without one. s_ready is high only while the sequencer is idle; a
// finished result sits in the output register and the next request may be
// taken while it waits for m_ready.
// ----------------------------------------------------------------------------
module buddy_hole_table_top
    import bht_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [KIND_W-1:0] s_kind,
    input  logic [SIZE_W-1:0] s_request_size,
    input  logic [ADDR_W-1:0] s_address,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic [ADDR_W-1:0] m_hole_address
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_INSERT0,
        S_RESP
    } state_t;

    // Sequencer and request registers.
    state_t              state_reg,     state_next;
    logic [KIND_W-1:0]   kind_reg,      kind_next;
    logic [SIZE_W-1:0]   size_reg,      size_next;
    logic [ADDR_W-1:0]   addr_reg,      addr_next;
    logic [ADDR_W-1:0]   low_reg,       low_next;
    logic                has_low_reg,   has_low_next;
    logic [ADDR_W+1:0]   high_reg,      high_next;
    logic [CNT_W-1:0]    count_reg,     count_next;
    logic [IDX_W-1:0]    rd_idx_reg,    rd_idx_next;
    logic [IDX_W-1:0]    last_idx_reg,  last_idx_next;
    logic                issue_reg,     issue_next;
    logic                ev_valid_reg,  ev_valid_next;
    logic [IDX_W-1:0]    ev_idx_reg,    ev_idx_next;
    logic                found_reg,     found_next;
    status_t             st_reg,        st_next;
    logic [ADDR_W-1:0]   res_addr_reg,  res_addr_next;

    // Output register.
    logic                m_valid_reg,   m_valid_next;
    status_t             m_status_reg,  m_status_next;
    logic [ADDR_W-1:0]   m_addr_reg,    m_addr_next;

    // Memory ports.
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    entry_t              ram_wentry;
    logic [ENTRY_W-1:0]  ram_rdata;
    entry_t              rd_entry;

    // Compare unit results for the entry currently on the read port.
    logic                size_ge;
    logic                size_gt;
    logic                buddy_hit;
    logic                hit;

    logic                out_free;
    logic                forward;
    logic                accept;
    logic [CNT_W-1:0]    count_m1;
    entry_t              new_entry;

    bht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_entry  = entry_t'(ram_rdata);
    assign new_entry = '{size: size_reg, start: addr_reg};

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign forward  = (kind_reg != KIND_GIVE);
    assign count_m1 = count_reg - CNT_W'(1);

    // The shared compare unit. Take wants the first hole at least as large as
    // the request, give stops at the first hole no larger than the new one
    // when walking down from the end, and buddy wants an exact size with a
    // start just below or just above the given address.
    always_comb begin
        size_ge   = (rd_entry.size >= size_reg);
        size_gt   = (rd_entry.size >  size_reg);
        buddy_hit = (rd_entry.size == size_reg) &&
                    ((has_low_reg && (rd_entry.start == low_reg)) ||
                     ({2'b00, rd_entry.start} == high_reg));
        hit       = (kind_reg == KIND_TAKE) ? size_ge : buddy_hit;
    end

    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        size_next     = size_reg;
        addr_next     = addr_reg;
        low_next      = low_reg;
        has_low_next  = has_low_reg;
        high_next     = high_reg;
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        last_idx_next = last_idx_reg;
        issue_next    = issue_reg;
        ev_valid_next = 1'b0;
        ev_idx_next   = ev_idx_reg;
        found_next    = found_reg;
        st_next       = st_reg;
        res_addr_next = res_addr_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_addr_next   = m_addr_reg;
        ram_we        = 1'b0;
        ram_waddr     = ev_idx_reg;
        ram_wentry    = rd_entry;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    kind_next     = s_kind;
                    size_next     = s_request_size;
                    addr_next     = s_address;
                    has_low_next  = ({1'b0, s_address} >= s_request_size);
                    low_next      = s_address - s_request_size[ADDR_W-1:0];
                    high_next     = {2'b00, s_address} + {1'b0, s_request_size};
                    found_next    = 1'b0;
                    res_addr_next = '0;
                    st_next       = ST_NONE;
                    issue_next    = 1'b1;
                    if (s_kind == KIND_GIVE) begin
                        rd_idx_next   = count_m1[IDX_W-1:0];
                        last_idx_next = '0;
                        if (count_reg == CNT_W'(ENTRIES)) begin
                            st_next    = ST_FULL;
                            state_next = S_RESP;
                        end else if (count_reg == '0) begin
                            state_next = S_INSERT0;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end else if (s_kind == KIND_TAKE || s_kind == KIND_BUDDY) begin
                        rd_idx_next   = '0;
                        last_idx_next = count_m1[IDX_W-1:0];
                        state_next    = (count_reg == '0) ? S_RESP : S_SCAN;
                    end else begin
                        state_next = S_RESP;
                    end
                end
            end

            S_SCAN: begin
                // Issue side: one read per cycle, forwards for take and buddy,
                // backwards from the last entry for give.
                if (issue_reg) begin
                    ev_valid_next = 1'b1;
                    ev_idx_next   = rd_idx_reg;
                    if (rd_idx_reg == last_idx_reg) begin
                        issue_next = 1'b0;
                    end else if (forward) begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                    end else begin
                        rd_idx_next = rd_idx_reg - IDX_W'(1);
                    end
                end

                // Evaluate side: the entry read in the previous cycle.
                if (ev_valid_reg) begin
                    if (forward) begin
                        if (!found_reg) begin
                            if (hit) begin
                                found_next    = 1'b1;
                                res_addr_next = rd_entry.start;
                            end
                        end else begin
                            // Close the gap left by the removed hole.
                            ram_we    = 1'b1;
                            ram_waddr = ev_idx_reg - IDX_W'(1);
                        end
                        if (ev_idx_reg == last_idx_reg) begin
                            ev_valid_next = 1'b0;
                            issue_next    = 1'b0;
                            state_next    = S_RESP;
                            if (found_reg || hit) begin
                                st_next    = ST_OK;
                                count_next = count_m1;
                            end
                        end
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = ev_idx_reg + IDX_W'(1);
                        if (size_gt) begin
                            // Larger hole moves up one place to open a gap.
                            if (ev_idx_reg == '0) begin
                                ev_valid_next = 1'b0;
                                issue_next    = 1'b0;
                                state_next    = S_INSERT0;
                            end
                        end else begin
                            ram_wentry    = new_entry;
                            ev_valid_next = 1'b0;
                            issue_next    = 1'b0;
                            count_next    = count_reg + CNT_W'(1);
                            st_next       = ST_OK;
                            state_next    = S_RESP;
                        end
                    end
                end
            end

            S_INSERT0: begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wentry = new_entry;
                count_next = count_reg + CNT_W'(1);
                st_next    = ST_OK;
                state_next = S_RESP;
            end

            S_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = st_reg;
                    m_addr_next   = (st_reg == ST_OK) ? res_addr_reg : '0;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            issue_reg    <= 1'b0;
            ev_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            issue_reg    <= issue_next;
            ev_valid_reg <= ev_valid_next;
            found_reg    <= found_next;
            m_valid_reg  <= m_valid_next;
            kind_reg     <= kind_next;
            size_reg     <= size_next;
            addr_reg     <= addr_next;
            low_reg      <= low_next;
            has_low_reg  <= has_low_next;
            high_reg     <= high_next;
            rd_idx_reg   <= rd_idx_next;
            last_idx_reg <= last_idx_next;
            ev_idx_reg   <= ev_idx_next;
            st_reg       <= st_next;
            res_addr_reg <= res_addr_next;
            m_status_reg <= m_status_next;
            m_addr_reg   <= m_addr_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_hole_address = m_addr_reg;

    // The hole count never exceeds the table size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(ENTRIES))
        else $error("hole count beyond table size");

    // A full status is only ever issued while the table really is full.
    a_full_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESP && out_free && st_reg == ST_FULL)
            |-> (count_reg == CNT_W'(ENTRIES)))
        else $error("full status with free table space");

    // Only a successful take or buddy carries an address.
    a_addr_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_hole_address == '0))
        else $error("address returned on a failed request");

    // The memory is written only by the walk or the front insertion.
    a_write_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_SCAN || state_reg == S_INSERT0))
        else $error("table write outside a walk");

    // The count moves by one at most, and only as a request completes.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
            (state_reg == S_RESP &&
             (count_reg == $past(count_reg) + CNT_W'(1) ||
              count_reg == $past(count_reg) - CNT_W'(1))))
        else $error("hole count changed unexpectedly");

endmodule
